FILE: design/lfu_cache_lru_tiebreak_top_assert.svh
// Assertion helpers included by the controller.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lfucache_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfucache_pkg;

  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam int CAPACITY_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    ACT_GET,
    ACT_PUT
  } action_e;

  typedef enum logic {
    UPD_HIT,
    UPD_INSERT
  } upd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

endpackage

`default_nettype wire

FILE: design/lfucache_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfucache_req_if
  import lfucache_pkg::*;
();
  logic                     valid;
  logic                     ready;
  action_e                  action;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] write_value;

  modport source (output valid, action, key, write_value, input ready);
  modport sink   (input valid, action, key, write_value, output ready);
endinterface

`default_nettype wire

FILE: design/lfucache_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfucache_rsp_if
  import lfucache_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;
  logic signed [DATA_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

FILE: design/lfucache_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One store slot. Folds its own entry into the scan record passed from the
// previous cell and registers it for the next; applies broadcast updates.
module lfucache_cell
  import lfucache_pkg::*;
#(
  parameter int  CAPACITY    = CAPACITY_DEF,
  parameter int  COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int  INDEX       = 0,
  parameter type cmd_t       = logic,
  parameter type scan_t      = logic
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  cmd_t  cmd_i,
  input  scan_t scan_i,
  output scan_t scan_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic                   valid_q, valid_d;
  logic [DATA_W-1:0]      key_q, key_d;
  logic [DATA_W-1:0]      value_q, value_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [IDX_W-1:0]       rank_q, rank_d;
  scan_t                  scan_q, scan_d;
  logic                   is_slot;

  assign is_slot = (cmd_i.slot == IDX_W'(INDEX));

  // scan merge
  always_comb begin
    scan_d = scan_i;
    if (valid_q) begin
      scan_d.occ = scan_i.occ + OCC_W'(1);
      if (key_q == cmd_i.key) begin
        scan_d.hit       = 1'b1;
        scan_d.hit_idx   = IDX_W'(INDEX);
        scan_d.hit_rank  = rank_q;
        scan_d.hit_value = value_q;
      end
      // lowest count wins, ties go to the oldest (highest rank)
      if (!scan_i.vic || (count_q < scan_i.vic_count) ||
          ((count_q == scan_i.vic_count) && (rank_q > scan_i.vic_rank))) begin
        scan_d.vic       = 1'b1;
        scan_d.vic_idx   = IDX_W'(INDEX);
        scan_d.vic_count = count_q;
        scan_d.vic_rank  = rank_q;
        scan_d.vic_key   = key_q;
      end
    end else if (!scan_i.free) begin
      scan_d.free     = 1'b1;
      scan_d.free_idx = IDX_W'(INDEX);
    end
  end

  // entry update
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    rank_d  = rank_q;
    if (cmd_i.upd_en) begin
      case (cmd_i.kind)
        UPD_HIT: begin
          if (is_slot) begin
            rank_d = '0;
            if (count_q != '1) count_d = count_q + COUNT_WIDTH'(1);
            if (cmd_i.write_en) value_d = cmd_i.value;
          end else if (valid_q && (rank_q < cmd_i.ref_rank)) begin
            rank_d = rank_q + IDX_W'(1);
          end
        end
        UPD_INSERT: begin
          if (is_slot) begin
            valid_d = 1'b1;
            key_d   = cmd_i.key;
            value_d = cmd_i.value;
            count_d = COUNT_WIDTH'(1);
            rank_d  = '0;
          end else if (valid_q && (!cmd_i.evict || (rank_q < cmd_i.ref_rank))) begin
            // younger than the victim, or no victim: moves into the victim's gap, opening rank 0 for the new entry
            rank_d = rank_q + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
    scan_q  <= scan_d;
  end

  assign scan_o = scan_q;

endmodule

`default_nettype wire

FILE: design/lfucache_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: takes an item, waits for the scan to ripple through the cell
// row, decides hit / insert / evict, broadcasts the update, loads the result.
module lfucache_ctrl
  import lfucache_pkg::*;
#(
  parameter int  CAPACITY = CAPACITY_DEF,
  parameter type cmd_t    = logic,
  parameter type scan_t   = logic
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  lfucache_req_if.sink          req,
  lfucache_rsp_if.source        rsp,
  input  wire                   cfg_we_i,
  input  wire [CAP_W-1:0]       cfg_wdata_i,
  output cmd_t                  cmd_o,
  input  scan_t                 scan_i
);

  `include "lfu_cache_lru_tiebreak_top_assert.svh"

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [CAP_W-1:0]  cap_q;
  action_e           action_q;
  logic [DATA_W-1:0] key_q, value_q;

  logic              rsp_valid_q;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] rdval_q, rdval_d;
  logic              ev_q, ev_d;
  logic [DATA_W-1:0] evkey_q, evkey_d;

  logic              accept, out_free, load;
  logic [LIM_W-1:0]  cap_ext, limit;
  logic              upd_en, upd_evict, upd_wr;
  upd_e              upd_kind;
  logic [IDX_W-1:0]  upd_slot, upd_rank;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid_q || rsp.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req.valid) state_d = ST_SCAN;
      ST_SCAN:   if (cnt_q == IDX_W'(CAPACITY - 1)) state_d = ST_DECIDE;
      ST_DECIDE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    load      = 1'b0;
    cnt_d     = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        req.ready = 1'b1;
        cnt_d     = '0;
      end
      ST_SCAN:   cnt_d = cnt_q + IDX_W'(1);
      ST_DECIDE: load  = out_free;
      default: ;
    endcase
  end

  // decision from the completed scan record
  assign cap_ext = LIM_W'(cap_q);
  assign limit   = (cap_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : cap_ext;

  always_comb begin
    hit_d     = 1'b0;
    rdval_d   = MISS_VALUE;
    ev_d      = 1'b0;
    evkey_d   = '0;
    upd_en    = 1'b0;
    upd_kind  = UPD_HIT;
    upd_evict = 1'b0;
    upd_wr    = 1'b0;
    upd_slot  = scan_i.hit_idx;
    upd_rank  = scan_i.hit_rank;
    if (limit != '0) begin
      if (scan_i.hit) begin
        hit_d  = 1'b1;
        upd_en = 1'b1;
        upd_wr = (action_q == ACT_PUT);
        if (action_q == ACT_GET) rdval_d = scan_i.hit_value;
      end else if (action_q == ACT_PUT) begin
        upd_kind = UPD_INSERT;
        if ((LIM_W'(scan_i.occ) >= limit) || !scan_i.free) begin
          if (scan_i.vic) begin
            upd_en    = 1'b1;
            upd_evict = 1'b1;
            upd_slot  = scan_i.vic_idx;
            upd_rank  = scan_i.vic_rank;
            ev_d      = 1'b1;
            evkey_d   = scan_i.vic_key;
          end
        end else begin
          upd_en   = 1'b1;
          upd_slot = scan_i.free_idx;
        end
      end
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.key      = key_q;
    cmd_o.value    = value_q;
    cmd_o.upd_en   = load && upd_en;
    cmd_o.kind     = upd_kind;
    cmd_o.slot     = upd_slot;
    cmd_o.ref_rank = upd_rank;
    cmd_o.evict    = upd_evict;
    cmd_o.write_en = upd_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= req.action;
      key_q    <= DATA_W'(req.key);
      value_q  <= DATA_W'(req.write_value);
    end
    if (load) begin
      hit_q   <= hit_d;
      rdval_q <= rdval_d;
      ev_q    <= ev_d;
      evkey_q <= evkey_d;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.hit         = hit_q;
  assign rsp.read_value  = rdval_q;
  assign rsp.evicted     = ev_q;
  assign rsp.evicted_key = evkey_q;

  `LFU_ASSERT_NEXT(a_accept_scan, clk_i, rst_ni, accept, state_q == ST_SCAN, "transfer did not start a scan")
  `LFU_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, (state_q == ST_DECIDE) && rsp_valid_q && !rsp.ready, (state_q == ST_DECIDE) && rsp_valid_q, "decision lost under output stall")
  `LFU_ASSERT_SAME(a_evict_put, clk_i, rst_ni, cmd_o.upd_en && cmd_o.evict, (action_q == ACT_PUT) && !scan_i.hit, "eviction without a missing put")

endmodule

`default_nettype wire

FILE: design/lfu_cache_lru_tiebreak_top.sv
`timescale 1ns / 1ps
`default_nettype none

// LFU key/value store, least-recent tie break.
// req_i (sink): valid/ready transfer of action (get/put), key, write_value.
// rsp_o (source): valid/ready transfer of hit, read_value, evicted,
//   evicted_key; exactly one result per request, in order.
// cfg_we_i/cfg_wdata_i: capacity limit write, taken on any edge with we high;
//   write it only while no request is in flight.
// Storage is a row of CAPACITY cells, one slot each. A request is latched,
// then a scan record (key match, first free slot, occupancy, eviction victim)
// ripples through the row one cell per clock. The controller then decides
// and broadcasts a single update to all cells while loading the result.
// A request is taken only in the idle state, so the cell row scans one request
//   at a time; the result is registered when the decide state loads it.
// Stall: a finished result sits in the output register; the next request is
//   accepted and scanned meanwhile, and its decide cycle waits until the
//   output register is free.
// Reset: all slots empty, capacity limit 16, no result pending.
module lfu_cache_lru_tiebreak_top
  import lfucache_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  lfucache_req_if.sink     req_i,
  lfucache_rsp_if.source   rsp_o,
  input  wire              cfg_we_i,
  input  wire [CAP_W-1:0]  cfg_wdata_i
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);

  // broadcast: match key during the scan, update on the decide cycle
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic              upd_en;
    upd_e              kind;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  ref_rank;   // rank of the hit entry or the victim
    logic              evict;
    logic              write_en;   // put on a present key
  } cmd_t;

  // record handed cell to cell
  typedef struct packed {
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic [DATA_W-1:0]      hit_value;
    logic                   free;
    logic [IDX_W-1:0]       free_idx;
    logic [OCC_W-1:0]       occ;
    logic                   vic;
    logic [IDX_W-1:0]       vic_idx;
    logic [COUNT_WIDTH-1:0] vic_count;
    logic [IDX_W-1:0]       vic_rank;
    logic [DATA_W-1:0]      vic_key;
  } scan_t;

  cmd_t  cmd;
  scan_t chain [CAPACITY+1];

  // head of the row starts with nothing found
  assign chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lfucache_cell #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH),
      .INDEX       (i),
      .cmd_t       (cmd_t),
      .scan_t      (scan_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .scan_i (chain[i]),
      .scan_o (chain[i+1])
    );
  end

  lfucache_ctrl #(
    .CAPACITY (CAPACITY),
    .cmd_t    (cmd_t),
    .scan_t   (scan_t)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .scan_i      (chain[CAPACITY])
  );

endmodule

`default_nettype wire
